/* hdl/ige_pkg.sv */
// Shared types, constants and helpers for the influence game equilibrium check.
// Holds the item and result structs, lane control struct and weight saturation.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package ige_pkg;

  localparam int MAX_NODES   = 64;
  localparam int WEIGHT_BITS = 16;

  localparam int NODE_BITS = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_BITS  = NODE_BITS + 1;
  localparam int LANES     = 1 << NODE_BITS;
  // Lane read register, lane term register, then one register per tree level.
  localparam int LAT       = 2 + NODE_BITS;
  localparam int BASE_BITS = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;
  localparam int SUM_BITS  = BASE_BITS + NODE_BITS + 1;

  localparam logic [1:0] CMD_WR_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_WR_THRESH = 2'd1;
  localparam logic [1:0] CMD_CHECK     = 2'd2;

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [NODE_BITS-1:0]          node_t;
  typedef logic [CNT_BITS-1:0]           count_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [5:0]          source_node;
    logic [5:0]          target_node;
    logic signed [15:0]  value;
    logic [63:0]         strategy;
  } item_t;

  typedef struct packed {
    logic        is_equilibrium;
    logic [5:0]  violating_node;
    logic [31:0] equilibria_found;
  } result_t;

  typedef struct packed {
    logic    wr;
    logic    rd;
    logic    take;
    logic    act;
    node_t   addr;
    weight_t wdata;
  } lane_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Clamp a Q8.8 value into the signed weight range.
  function automatic weight_t sat_weight(input logic signed [15:0] v);
    logic signed [32:0] wide;
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    wide = {{17{v[15]}}, v};
    hi   = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
    lo   = -hi - 33'sd1;
    if (wide > hi) begin
      return hi[WEIGHT_BITS-1:0];
    end else if (wide < lo) begin
      return lo[WEIGHT_BITS-1:0];
    end else begin
      return wide[WEIGHT_BITS-1:0];
    end
  endfunction

endpackage

/* hdl/ige_lane.sv */
// One source-node lane: a column of the weight matrix and the signed term it adds.
// Depends on ige_pkg for the lane control struct, weight and sum types.
// Read data and the term are both registered.
module ige_lane (
  input  logic                clk,
  input  ige_pkg::lane_ctrl_t ctrl,
  output ige_pkg::sum_t       term
);

  ige_pkg::weight_t mem [ige_pkg::MAX_NODES];
  ige_pkg::weight_t rdata;
  logic             take_q;
  logic             act_q;
  ige_pkg::sum_t    wext;

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[ctrl.addr] <= ctrl.wdata;
    end
    if (ctrl.rd) begin
      rdata <= mem[ctrl.addr];
    end
    take_q <= ctrl.take;
    act_q  <= ctrl.act;
  end

  assign wext = ige_pkg::SUM_BITS'(rdata);

  // Add the weight for +1, subtract it for -1, drop it for self or inactive nodes.
  always_ff @(posedge clk) begin
    if (!take_q) begin
      term <= '0;
    end else if (act_q) begin
      term <= wext;
    end else begin
      term <= -wext;
    end
  end

endmodule

/* hdl/ige_merge.sv */
// Registered adder tree that merges the lane terms into one node's weighted sum.
// Depends on ige_pkg for the sum type and the lane count.
// One register per tree level.
module ige_merge (
  input  logic                                  clk,
  input  ige_pkg::sum_t [ige_pkg::LANES-1:0]    terms,
  output ige_pkg::sum_t                         total
);

  // Heap layout: acc[1] is the root, children of k are 2k and 2k+1;
  // indices at or above LANES are the lane terms themselves.
  ige_pkg::sum_t acc [1:ige_pkg::LANES-1];

  for (genvar k = 1; k < ige_pkg::LANES; k++) begin : g_node
    ige_pkg::sum_t left;
    ige_pkg::sum_t right;
    if (2 * k >= ige_pkg::LANES) begin : g_leaf
      assign left  = terms[2 * k - ige_pkg::LANES];
      assign right = terms[2 * k + 1 - ige_pkg::LANES];
    end else begin : g_inner
      assign left  = acc[2 * k];
      assign right = acc[2 * k + 1];
    end
    always_ff @(posedge clk) begin
      acc[k] <= left + right;
    end
  end

  assign total = acc[1];

endmodule

/* hdl/influence_game_equilibrium_check.sv */
// Top level of the influence game pure Nash equilibrium check.
// Depends on ige_pkg, ige_lane (one weight column per source node) and ige_merge.
// Holds the sequencer, threshold store, comparison, first-violator capture and counter.
//
// Channel    Ports                          Handshake
// ---------  -----------------------------  -------------------------------------------
// item in    item (ige_pkg::item_t)         taken when start is high and busy is low
// result     result (ige_pkg::result_t)     valid for one cycle while done is high
// config     cfg_wr_en, cfg_wr_data[6:0]    written when cfg_wr_en is high, no wait
//
// Weight and threshold writes never raise busy.
// A check issues nodes 0 to n - 1 in turn, where n is the clamped active node count:
// one node's sum enters the lanes per cycle, then passes the two lane registers, the
// adder tree levels and the result register. busy is low again in the cycle that done
// is high, so the next item can be taken at the same edge as the result. With no
// players the check ends at once.
// rst is synchronous and active high; it clears the sequencer, the pipeline valids,
// the equilibrium counter and sets active_nodes to 64. Both stores stay undefined.
// done cannot be stalled: the receiver must take each result in its cycle.
module influence_game_equilibrium_check (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ige_pkg::item_t   item,
  output logic             busy,
  input  logic             cfg_wr_en,
  input  logic [6:0]       cfg_wr_data,
  output logic             done,
  output ige_pkg::result_t result
);

  localparam int NB  = ige_pkg::NODE_BITS;
  localparam int CB  = ige_pkg::CNT_BITS;
  localparam int LAT = ige_pkg::LAT;

  // Control and configuration
  ige_pkg::state_t state;
  ige_pkg::state_t state_next;
  logic [6:0]      active_nodes;
  ige_pkg::count_t n_act;
  ige_pkg::count_t issue_cnt;
  logic            accept;
  logic            issuing;
  logic            finish;
  ige_pkg::node_t  rd_node;
  logic            wr_weight;
  logic            wr_thresh;
  logic [63:0]     strat_q;

  // Per-node pipeline alongside the lanes and the tree
  logic                  vld_p  [LAT];
  logic                  last_p [LAT];
  logic                  act_p  [LAT];
  ige_pkg::node_t        node_p [LAT];
  logic signed [15:0]    thr_p  [LAT];
  logic signed [15:0]    thr_mem [ige_pkg::MAX_NODES];

  // Lanes and merge
  ige_pkg::lane_ctrl_t                        lane_ctrl [ige_pkg::LANES];
  ige_pkg::sum_t [ige_pkg::LANES-1:0]         terms;
  ige_pkg::sum_t                              total;

  // Verdict
  ige_pkg::sum_t  thr_ext;
  logic           viol_now;
  logic           found;
  ige_pkg::node_t bad;
  logic           eq_final;
  ige_pkg::node_t bad_final;
  logic [31:0]    eq_count;

  assign accept = start && !busy;

  // Clamp the player count to the number of lanes.
  assign n_act = (active_nodes > 7'(ige_pkg::MAX_NODES)) ? CB'(ige_pkg::MAX_NODES)
                                                         : active_nodes[CB-1:0];

  assign rd_node = issue_cnt[NB-1:0];

  assign wr_weight = accept && (item.cmd == ige_pkg::CMD_WR_WEIGHT)
                     && ({1'b0, item.source_node} < 7'(ige_pkg::MAX_NODES))
                     && ({1'b0, item.target_node} < 7'(ige_pkg::MAX_NODES));
  assign wr_thresh = accept && (item.cmd == ige_pkg::CMD_WR_THRESH)
                     && ({1'b0, item.target_node} < 7'(ige_pkg::MAX_NODES));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ige_pkg::ST_IDLE: begin
        if (accept && (item.cmd == ige_pkg::CMD_CHECK)) begin
          state_next = ige_pkg::ST_RUN;
        end
      end
      ige_pkg::ST_RUN: begin
        if (finish) begin
          state_next = ige_pkg::ST_IDLE;
        end
      end
      default: state_next = ige_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    issuing = 1'b0;
    case (state)
      ige_pkg::ST_IDLE: begin
        busy    = 1'b0;
        issuing = 1'b0;
      end
      ige_pkg::ST_RUN: begin
        busy    = 1'b1;
        issuing = (issue_cnt < n_act);
      end
      default: begin
        busy    = 1'b0;
        issuing = 1'b0;
      end
    endcase
  end

  // The check ends when the last node's sum leaves the tree, or at once with no players.
  assign finish = (state == ige_pkg::ST_RUN)
                  && ((n_act == '0) || (vld_p[LAT-1] && last_p[LAT-1]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ige_pkg::ST_IDLE;
      active_nodes <= 7'd64;
      issue_cnt    <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        active_nodes <= cfg_wr_data;
      end
      if (accept) begin
        issue_cnt <= '0;
      end else if (issuing) begin
        issue_cnt <= issue_cnt + CB'(1);
      end
    end
  end

  // Hold the strategy for the whole check.
  always_ff @(posedge clk) begin
    if (accept && (item.cmd == ige_pkg::CMD_CHECK)) begin
      strat_q <= item.strategy;
    end
  end

  // ---------------------------------------------------------------------------
  // Threshold store: written by items, read once per issued node below
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_thresh) begin
      thr_mem[item.target_node[NB-1:0]] <= item.value;
    end
  end

  // ---------------------------------------------------------------------------
  // Node pipeline: valid, last flag, own action, threshold and index travel with the sum
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        vld_p[k] <= 1'b0;
      end
    end else begin
      vld_p[0] <= issuing;
      for (int k = 1; k < LAT; k++) begin
        vld_p[k] <= vld_p[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issuing) begin
      thr_p[0] <= thr_mem[rd_node];
    end
    last_p[0] <= (issue_cnt == (n_act - CB'(1)));
    act_p[0]  <= strat_q[rd_node];
    node_p[0] <= rd_node;
    for (int k = 1; k < LAT; k++) begin
      last_p[k] <= last_p[k-1];
      act_p[k]  <= act_p[k-1];
      node_p[k] <= node_p[k-1];
      thr_p[k]  <= thr_p[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Lanes: lane j holds the weights from node j and adds +/- w(j -> i)
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < ige_pkg::LANES; j++) begin : g_lane
    if (j < ige_pkg::MAX_NODES) begin : g_used
      always_comb begin
        lane_ctrl[j].wr    = wr_weight && (item.source_node[NB-1:0] == NB'(j));
        lane_ctrl[j].rd    = issuing;
        lane_ctrl[j].take  = (CB'(j) < n_act) && (rd_node != NB'(j));
        lane_ctrl[j].act   = strat_q[j];
        lane_ctrl[j].addr  = busy ? rd_node : item.target_node[NB-1:0];
        lane_ctrl[j].wdata = ige_pkg::sat_weight(item.value);
      end
      ige_lane u_lane (
        .clk  (clk),
        .ctrl (lane_ctrl[j]),
        .term (terms[j])
      );
    end else begin : g_pad
      // Pad the tree to a power of two with zero terms.
      assign lane_ctrl[j] = '0;
      assign terms[j]     = '0;
    end
  end

  ige_merge u_merge (
    .clk   (clk),
    .terms (terms),
    .total (total)
  );

  // ---------------------------------------------------------------------------
  // Compare each node's sum with its threshold; a tie never violates
  // ---------------------------------------------------------------------------
  assign thr_ext  = ige_pkg::SUM_BITS'(thr_p[LAT-1]);
  assign viol_now = vld_p[LAT-1]
                    && (((total > thr_ext) && !act_p[LAT-1])
                        || ((total < thr_ext) && act_p[LAT-1]));

  assign eq_final  = !(found || viol_now);
  assign bad_final = found ? bad : (viol_now ? node_p[LAT-1] : '0);

  // Capture the lowest violating node; nodes leave the tree in index order.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (viol_now && !found) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (viol_now && !found) begin
      bad <= node_p[LAT-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Counter and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      eq_count <= '0;
      done     <= 1'b0;
    end else begin
      done <= finish;
      if (finish && eq_final && (eq_count != '1)) begin
        eq_count <= eq_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.is_equilibrium   <= eq_final;
      result.violating_node   <= 6'(bad_final);
      result.equilibria_found <= (eq_final && (eq_count != '1)) ? eq_count + 32'd1
                                                                : eq_count;
    end
  end

endmodule
